// ===== rtl/core/text_to_integer_parser_macros.svh =====
// ---------------------------------------------------------------------------
// text_to_integer_parser_macros
// Assertion shorthands used by the parser top-level RTL.
// ---------------------------------------------------------------------------
`ifndef TEXT_TO_INTEGER_PARSER_MACROS_SVH
`define TEXT_TO_INTEGER_PARSER_MACROS_SVH

// Concurrent check on an explicit clock and active-low reset.
`define TTIP_ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent check on the block's own clock and reset.
`define TTIP_ASSERT(label, prop, msg) \
  `TTIP_ASSERT_CLK(label, clk_i, rst_ni, prop, msg)

`endif

// ===== rtl/core/ttip_pkg.sv =====
// ---------------------------------------------------------------------------
// ttip_pkg
// Types and constants for the text-to-integer parser.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package ttip_pkg;

  localparam int unsigned CharCodeW       = 16;
  localparam int unsigned CharBitsDefault = 16;
  localparam int unsigned ValueW          = 32;
  localparam int unsigned PosW            = 2;
  localparam int unsigned DigitW          = 4;

  localparam logic [PosW-1:0] PosFirst  = 2'd0;
  localparam logic [PosW-1:0] PosSecond = 2'd1;
  localparam logic [PosW-1:0] PosRest   = 2'd2;

  // 7-bit ASCII codes; anything above 0x7F is never a digit
  localparam logic [6:0] AsciiZero  = 7'h30;
  localparam logic [6:0] AsciiNine  = 7'h39;
  localparam logic [6:0] AsciiLowA  = 7'h61;
  localparam logic [6:0] AsciiLowF  = 7'h66;
  localparam logic [6:0] AsciiMinus = 7'h2D;
  localparam logic [6:0] AsciiLowX  = 7'h78;
  localparam logic [6:0] CaseBit    = 7'h20;

  localparam logic [ValueW-1:0] BaseDec      = 32'd10;
  localparam int unsigned       BaseHexShift = 4;

  typedef struct packed {
    logic [PosW-1:0]   char_position;
    logic              hex_mode;
    logic              negative_flag;
    logic              parse_stopped;
    logic              digit_seen;
    logic [ValueW-1:0] accumulator;
  } parse_state_t;

  typedef struct packed {
    logic              valid;
    logic [ValueW-1:0] value;
    logic              used_default;
  } parse_result_t;

endpackage

// ===== rtl/core/ttip_step.sv =====
// ---------------------------------------------------------------------------
// ttip_step
// Next-state and result logic for one character of the string.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ttip_step
  import ttip_pkg::*;
#(
  parameter int unsigned CHAR_BITS = CharBitsDefault
) (
  input  parse_state_t        state_i,
  input  logic [CHAR_BITS-1:0] char_i,
  input  logic [ValueW-1:0]   default_value_i,
  output parse_state_t        state_o,
  output parse_result_t       result_o
);

  logic              hi_zero;
  logic [6:0]        low7;
  logic [6:0]        folded;
  logic              is_nul;
  logic              is_num;
  logic              is_letter;
  logic              is_minus;
  logic              is_x;
  logic [DigitW-1:0] digit;
  logic [ValueW-1:0] acc_scaled;
  logic              hex_switch;

  assign hi_zero   = (char_i[CHAR_BITS-1:7] == '0);
  assign low7      = char_i[6:0];
  assign folded    = low7 | CaseBit;
  assign is_nul    = (char_i == '0);
  assign is_num    = hi_zero && (low7 >= AsciiZero) && (low7 <= AsciiNine);
  assign is_letter = hi_zero && (folded >= AsciiLowA) && (folded <= AsciiLowF);
  assign is_minus  = hi_zero && (low7 == AsciiMinus);
  assign is_x      = hi_zero && (folded == AsciiLowX);

  always_comb begin
    if (is_num) begin
      digit = DigitW'(low7 - AsciiZero);
    end else begin
      digit = DigitW'(folded - AsciiLowA + 7'd10);
    end
  end

  assign acc_scaled = state_i.hex_mode ? (state_i.accumulator << BaseHexShift)
                                       : (state_i.accumulator * BaseDec);

  // a lone leading '0' followed by x/X turns into the hex prefix
  assign hex_switch = (state_i.char_position == PosSecond) && state_i.digit_seen &&
                      (state_i.accumulator == '0) && !state_i.negative_flag &&
                      !state_i.hex_mode && is_x;

  always_comb begin
    state_o               = state_i;
    result_o.valid        = 1'b0;
    result_o.used_default = !state_i.digit_seen;
    if (!state_i.digit_seen) begin
      result_o.value = default_value_i;
    end else if (state_i.negative_flag) begin
      result_o.value = '0 - state_i.accumulator;
    end else begin
      result_o.value = state_i.accumulator;
    end

    if (is_nul) begin
      result_o.valid = 1'b1;
      state_o        = '0;
    end else begin
      if (state_i.char_position != PosRest) begin
        state_o.char_position = state_i.char_position + 1'b1;
      end
      if (state_i.parse_stopped) begin
        // rest of the string is skipped
      end else if ((state_i.char_position == PosFirst) && is_minus) begin
        state_o.negative_flag = 1'b1;
      end else if (hex_switch) begin
        state_o.hex_mode   = 1'b1;
        state_o.digit_seen = 1'b0;
      end else if (!(is_num || is_letter)) begin
        state_o.parse_stopped = 1'b1;
      end else begin
        state_o.accumulator = acc_scaled + {{(ValueW-DigitW){1'b0}}, digit};
        state_o.digit_seen  = 1'b1;
      end
    end
  end

endmodule

// ===== rtl/core/text_to_integer_parser.sv =====
// ---------------------------------------------------------------------------
// text_to_integer_parser
// Parses a decimal or 0x-prefixed hex character stream into a 32-bit integer.
// ---------------------------------------------------------------------------
//  channel   direction  word
//  s_axis    in         tdata[15:0] = char_code
//  m_axis    out        tdata[31:0] = value, tuser[0] = used_default
//  cfg       in         cfg_data_i = default_value (always ready)
//
//  One character per cycle sustained while no NUL stalls; the accumulator
//  multiply-add is combinational logic between the input register and the
//  state/result registers. A NUL's result passes the input register and the
//  output register to m_axis. Reset clears the string state and default_value
//  to zero; no clearing pass. Only a NUL waits on a full, stalled output
//  register; other characters keep flowing while a result sits unclaimed.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "text_to_integer_parser_macros.svh"

module text_to_integer_parser
  import ttip_pkg::*;
#(
  parameter int unsigned CHAR_BITS = CharBitsDefault
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  input  logic [CharCodeW-1:0]     s_axis_tdata,   // [15:0] char_code
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  output logic [ValueW-1:0]        m_axis_tdata,   // [31:0] value
  output logic [0:0]               m_axis_tuser,   // [0] used_default
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic signed [ValueW-1:0] cfg_data_i
);

  logic                 in_valid_q;
  logic [CHAR_BITS-1:0] in_char_q;
  parse_state_t         state_q;
  parse_state_t         state_d;
  parse_result_t        step_res;
  logic [ValueW-1:0]    default_q;
  logic                 out_valid_q;
  logic [ValueW-1:0]    out_value_q;
  logic                 out_used_q;
  logic                 process;
  logic                 out_load;

  ttip_step #(
    .CHAR_BITS(CHAR_BITS)
  ) u_step (
    .state_i        (state_q),
    .char_i         (in_char_q),
    .default_value_i(default_q),
    .state_o        (state_d),
    .result_o       (step_res)
  );

  // a NUL may only retire when the output register is free or being taken
  assign process  = in_valid_q && (!step_res.valid || !out_valid_q || m_axis_tready);
  assign out_load = process && step_res.valid;

  assign s_axis_tready = !in_valid_q || process;
  assign cfg_ready_o   = 1'b1;

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_value_q;
  assign m_axis_tuser  = out_used_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      state_q     <= '0;
      out_valid_q <= 1'b0;
      default_q   <= '0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (process) begin
        state_q <= state_d;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_valid_i) begin
        default_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_char_q <= s_axis_tdata[CHAR_BITS-1:0];
    end
    if (out_load) begin
      out_value_q <= step_res.value;
      out_used_q  <= step_res.used_default;
    end
  end

  `TTIP_ASSERT(a_no_overwrite, out_valid_q && !m_axis_tready |-> !out_load, "result overwritten")
  `TTIP_ASSERT(a_clear_after_nul, out_load |=> state_q == '0, "string state not cleared")
  `TTIP_ASSERT(a_hex_pos, state_q.hex_mode |-> state_q.char_position == PosRest, "hex without prefix")

endmodule
